// ===== rtl/stok_pkg.sv =====
// Shared types, token codes and character constants for the source tokenizer.
`default_nettype none

package stok_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       at_end;
	} src_item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [2:0]  error_kind;
		logic [19:0] line;
		logic [23:0] start_offset;
		logic [7:0]  lexeme_length;
		logic        last;
	} tok_item_t;

	typedef enum logic [2:0] {
		M_IDLE,
		M_SLASH,
		M_COMMENT,
		M_OP,
		M_IDENT,
		M_NUMBER,
		M_ZERO
	} mode_t;

	// token kinds
	localparam logic [5:0] TK_END      = 6'd0;
	localparam logic [5:0] TK_LPAREN   = 6'd1;
	localparam logic [5:0] TK_RPAREN   = 6'd2;
	localparam logic [5:0] TK_LBRACK   = 6'd3;
	localparam logic [5:0] TK_RBRACK   = 6'd4;
	localparam logic [5:0] TK_LBRACE   = 6'd5;
	localparam logic [5:0] TK_RBRACE   = 6'd6;
	localparam logic [5:0] TK_BANG     = 6'd7;
	localparam logic [5:0] TK_COLON    = 6'd8;
	localparam logic [5:0] TK_DOT      = 6'd9;
	localparam logic [5:0] TK_COMMA    = 6'd10;
	localparam logic [5:0] TK_SEMI     = 6'd11;
	localparam logic [5:0] TK_PLUS     = 6'd12;
	localparam logic [5:0] TK_MINUS    = 6'd15;
	localparam logic [5:0] TK_STAR     = 6'd18;
	localparam logic [5:0] TK_SLASH    = 6'd20;
	localparam logic [5:0] TK_SLASH_EQ = 6'd21;
	localparam logic [5:0] TK_PERCENT  = 6'd22;
	localparam logic [5:0] TK_LT       = 6'd24;
	localparam logic [5:0] TK_GT       = 6'd26;
	localparam logic [5:0] TK_ASSIGN   = 6'd28;
	localparam logic [5:0] TK_DEF      = 6'd30;
	localparam logic [5:0] TK_LET      = 6'd31;
	localparam logic [5:0] TK_IF       = 6'd32;
	localparam logic [5:0] TK_THEN     = 6'd33;
	localparam logic [5:0] TK_ELSE     = 6'd34;
	localparam logic [5:0] TK_AND      = 6'd35;
	localparam logic [5:0] TK_OR       = 6'd36;
	localparam logic [5:0] TK_IDENT    = 6'd37;
	localparam logic [5:0] TK_NUMBER   = 6'd38;
	localparam logic [5:0] TK_ERROR    = 6'd39;

	// offsets from an operator's base kind
	localparam logic [5:0] OP_EQ_STEP  = 6'd1;
	localparam logic [5:0] OP_DBL_STEP = 6'd2;

	// error kinds
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_INVALID  = 3'd1;
	localparam logic [2:0] ERR_DOT      = 3'd2;
	localparam logic [2:0] ERR_LETTER   = 3'd3;
	localparam logic [2:0] ERR_TOO_LONG = 3'd4;

	// characters
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_EQ      = 8'h3D;
	localparam logic [7:0] CH_GT      = 8'h3E;

	// keyword spellings, packed as the first bytes of an identifier
	localparam logic [31:0] KW_DEF  = 32'h0064_6566;
	localparam logic [31:0] KW_LET  = 32'h006C_6574;
	localparam logic [31:0] KW_AND  = 32'h0061_6E64;
	localparam logic [31:0] KW_IF   = 32'h0000_6966;
	localparam logic [31:0] KW_OR   = 32'h0000_6F72;
	localparam logic [31:0] KW_THEN = 32'h7468_656E;
	localparam logic [31:0] KW_ELSE = 32'h656C_7365;

	localparam logic [19:0] LINE_OUT_MAX = 20'hFFFFF;
	localparam logic [7:0]  LEN_OUT_MAX  = 8'hFF;

	// result queue
	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = 2;
	localparam int QCNT_BITS = 3;

	function automatic logic [5:0] punct_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			8'h28:   k = TK_LPAREN;
			8'h29:   k = TK_RPAREN;
			8'h5B:   k = TK_LBRACK;
			8'h5D:   k = TK_RBRACK;
			8'h7B:   k = TK_LBRACE;
			8'h7D:   k = TK_RBRACE;
			8'h21:   k = TK_BANG;
			8'h3A:   k = TK_COLON;
			8'h2E:   k = TK_DOT;
			8'h2C:   k = TK_COMMA;
			8'h3B:   k = TK_SEMI;
			default: k = TK_END;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] op_base(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			CH_PLUS:    k = TK_PLUS;
			CH_MINUS:   k = TK_MINUS;
			CH_STAR:    k = TK_STAR;
			CH_PERCENT: k = TK_PERCENT;
			CH_LT:      k = TK_LT;
			CH_GT:      k = TK_GT;
			default:    k = TK_ASSIGN;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/source_tokenizer.sv =====
// Streaming source tokenizer: one byte in per transfer, tokens out through a short queue.
`default_nettype none

// Takes one source byte (or an end mark) per transfer and reports tokens by kind, error kind,
// line, start offset and length. Every byte is handled in the cycle it is accepted, so a byte
// can be taken every cycle while src_stall is low; a byte yields zero, one or two tokens.
// Tokens leave through a four-entry queue at one per cycle while tok_stall is low, and
// src_stall rises whenever fewer than two entries are free. Bytes that each yield two tokens
// (a token closed by punctuation or an invalid byte) therefore slow the input to the pace
// of the output's one token per cycle. After reset no clearing is needed. An end mark flushes
// any pending token, emits the end token and returns the line and offset counters to 1 and 0.
module source_tokenizer #(
	parameter int LENGTH_MAX  = 255,
	parameter int OFFSET_BITS = 24,
	parameter int LINE_BITS   = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 src_valid,
	output logic                      src_stall,
	input  wire stok_pkg::src_item_t  src_item,
	output logic                      tok_valid,
	input  wire logic                 tok_stall,
	output stok_pkg::tok_item_t       tok_item
);
	import stok_pkg::*;

	localparam int RUN_BITS = $clog2(LENGTH_MAX + 2);
	localparam logic [RUN_BITS-1:0]  LEN_LIM  = RUN_BITS'(LENGTH_MAX);
	localparam logic [LINE_BITS-1:0] LINE_SAT = {LINE_BITS{1'b1}};

	// scanner state
	mode_t                  mode_q, mode_d;
	logic [7:0]             pend_q, pend_d;
	logic                   dot_q, dot_d;
	logic [RUN_BITS-1:0]    run_q, run_d;
	logic [31:0]            kw_q, kw_d;
	logic [OFFSET_BITS-1:0] tstart_q, tstart_d;
	logic [OFFSET_BITS-1:0] off_q, off_d;
	logic [LINE_BITS-1:0]   line_q, line_d;

	// result queue
	tok_item_t              fifo_q [QDEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0]   cnt_q;

	logic                   src_acc, tok_acc;
	logic [7:0]             c;
	logic                   c_alpha, c_digit, c_space, c_op;
	logic [5:0]             c_punct;
	logic [32:0]            line_wide, run_wide;
	logic [19:0]            line_out;
	logic [7:0]             run_out;
	logic                   too_long;
	logic [5:0]             id_kind;
	tok_item_t              ident_tok, num_end_tok, num_term_tok;
	tok_item_t              tok_a, tok_b, push0, push1;
	logic                   va, vb, do_idle;
	logic [1:0]             n_push;

	function automatic tok_item_t mk_tok(input logic [5:0] k, input logic [2:0] e,
			input logic [OFFSET_BITS-1:0] st, input logic [7:0] len, input logic [19:0] ln);
		tok_item_t   t;
		logic [32:0] sw;
		sw              = 33'(st);
		t.token_kind    = k;
		t.error_kind    = e;
		t.line          = ln;
		t.start_offset  = sw[23:0];
		t.lexeme_length = len;
		t.last          = 1'b0;
		return t;
	endfunction

	assign src_acc   = src_valid && !src_stall;
	assign tok_valid = (cnt_q != '0);
	assign tok_acc   = tok_valid && !tok_stall;
	assign src_stall = (cnt_q > QCNT_BITS'(QDEPTH - 2));
	assign tok_item  = fifo_q[rd_ptr_q];

	assign c       = src_item.ch;
	assign c_alpha = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
	assign c_digit = (c inside {[8'h30:8'h39]});
	assign c_space = (c == 8'h20) || (c inside {[8'h09:8'h0D]});
	assign c_op    = (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_PERCENT, CH_LT, CH_GT, CH_EQ});
	assign c_punct = punct_kind(c);

	assign line_wide = 33'(line_q);
	assign line_out  = (line_wide > 33'(LINE_OUT_MAX)) ? LINE_OUT_MAX : line_wide[19:0];
	assign run_wide  = 33'(run_q);
	assign run_out   = (run_wide > 33'(LEN_OUT_MAX)) ? LEN_OUT_MAX : run_wide[7:0];
	assign too_long  = (run_q > LEN_LIM);

	always_comb begin
		id_kind = TK_IDENT;
		if (run_wide == 33'd3) begin
			if (kw_q == KW_DEF)      id_kind = TK_DEF;
			else if (kw_q == KW_LET) id_kind = TK_LET;
			else if (kw_q == KW_AND) id_kind = TK_AND;
		end else if (run_wide == 33'd2) begin
			if (kw_q == KW_IF)       id_kind = TK_IF;
			else if (kw_q == KW_OR)  id_kind = TK_OR;
		end else if (run_wide == 33'd4) begin
			if (kw_q == KW_THEN)      id_kind = TK_THEN;
			else if (kw_q == KW_ELSE) id_kind = TK_ELSE;
		end
	end

	always_comb begin
		if (too_long) begin
			ident_tok    = mk_tok(TK_ERROR, ERR_TOO_LONG, tstart_q, run_out, line_out);
			num_end_tok  = ident_tok;
			num_term_tok = ident_tok;
		end else begin
			ident_tok   = mk_tok(id_kind, ERR_NONE, tstart_q, run_out, line_out);
			num_end_tok = mk_tok(TK_NUMBER, ERR_NONE, tstart_q, run_out, line_out);
			// terminating byte decides between a clean number and an error
			if (c == CH_DOT && dot_q)
				num_term_tok = mk_tok(TK_ERROR, ERR_DOT, tstart_q, run_out, line_out);
			else if (c_alpha)
				num_term_tok = mk_tok(TK_ERROR, ERR_LETTER, tstart_q, run_out, line_out);
			else
				num_term_tok = num_end_tok;
		end
	end

	always_comb begin
		mode_d   = mode_q;
		pend_d   = pend_q;
		dot_d    = dot_q;
		run_d    = run_q;
		kw_d     = kw_q;
		tstart_d = tstart_q;
		off_d    = off_q;
		line_d   = line_q;
		va       = 1'b0;
		vb       = 1'b0;
		do_idle  = 1'b0;
		tok_a    = mk_tok(TK_END, ERR_NONE, tstart_q, 8'd0, line_out);
		tok_b    = mk_tok(TK_END, ERR_NONE, off_q, 8'd0, line_out);

		if (src_item.at_end) begin
			unique case (mode_q)
				M_SLASH: begin
					va    = 1'b1;
					tok_a = mk_tok(TK_SLASH, ERR_NONE, tstart_q, 8'd1, line_out);
				end
				M_OP: begin
					va    = 1'b1;
					tok_a = mk_tok(op_base(pend_q), ERR_NONE, tstart_q, 8'd1, line_out);
				end
				M_IDENT: begin
					va    = 1'b1;
					tok_a = ident_tok;
				end
				M_NUMBER, M_ZERO: begin
					va    = 1'b1;
					tok_a = num_end_tok;
				end
				default: ;
			endcase
			vb       = 1'b1;
			mode_d   = M_IDLE;
			pend_d   = '0;
			dot_d    = 1'b0;
			run_d    = '0;
			kw_d     = '0;
			tstart_d = '0;
			off_d    = '0;
			line_d   = LINE_BITS'(1);
		end else begin
			unique case (mode_q)
				M_SLASH: begin
					if (c == CH_SLASH) begin
						mode_d = M_COMMENT;
					end else if (c == CH_EQ) begin
						va     = 1'b1;
						tok_a  = mk_tok(TK_SLASH_EQ, ERR_NONE, tstart_q, 8'd2, line_out);
						mode_d = M_IDLE;
					end else begin
						va      = 1'b1;
						tok_a   = mk_tok(TK_SLASH, ERR_NONE, tstart_q, 8'd1, line_out);
						do_idle = 1'b1;
					end
				end
				M_COMMENT: begin
					do_idle = (c == CH_NL);
				end
				M_OP: begin
					va = 1'b1;
					if (c == CH_EQ) begin
						tok_a  = mk_tok(op_base(pend_q) + OP_EQ_STEP, ERR_NONE, tstart_q, 8'd2,
							line_out);
						mode_d = M_IDLE;
					end else if (c == pend_q && (c == CH_PLUS || c == CH_MINUS)) begin
						tok_a  = mk_tok(op_base(pend_q) + OP_DBL_STEP, ERR_NONE, tstart_q, 8'd2,
							line_out);
						mode_d = M_IDLE;
					end else begin
						tok_a   = mk_tok(op_base(pend_q), ERR_NONE, tstart_q, 8'd1, line_out);
						do_idle = 1'b1;
					end
				end
				M_IDENT: begin
					if (c_alpha || c_digit) begin
						if (run_wide < 33'd4)
							kw_d = {kw_q[23:0], c};
						if (!too_long)
							run_d = run_q + 1'b1;
					end else begin
						va      = 1'b1;
						tok_a   = ident_tok;
						do_idle = 1'b1;
					end
				end
				M_NUMBER, M_ZERO: begin
					if (mode_q == M_ZERO && c_digit) begin
						// leading zero: the zero alone is an error, the digit starts afresh
						va      = 1'b1;
						tok_a   = mk_tok(TK_ERROR, ERR_INVALID, tstart_q, 8'd1, line_out);
						do_idle = 1'b1;
					end else if (c_digit || (c == CH_DOT && !dot_q)) begin
						if (c == CH_DOT)
							dot_d = 1'b1;
						if (!too_long)
							run_d = run_q + 1'b1;
						mode_d = M_NUMBER;
					end else begin
						va      = 1'b1;
						tok_a   = num_term_tok;
						do_idle = 1'b1;
					end
				end
				default: do_idle = 1'b1;
			endcase

			if (do_idle) begin
				mode_d = M_IDLE;
				if (c_space) begin
					if (c == CH_NL && line_q < LINE_SAT)
						line_d = line_q + 1'b1;
				end else if (c_punct != TK_END) begin
					vb    = 1'b1;
					tok_b = mk_tok(c_punct, ERR_NONE, off_q, 8'd1, line_out);
				end else begin
					tstart_d = off_q;
					if (c == CH_SLASH) begin
						mode_d = M_SLASH;
					end else if (c_op) begin
						mode_d = M_OP;
						pend_d = c;
					end else if (c_alpha) begin
						mode_d = M_IDENT;
						run_d  = RUN_BITS'(1);
						kw_d   = 32'(c);
					end else if (c_digit) begin
						mode_d = (c == CH_ZERO) ? M_ZERO : M_NUMBER;
						run_d  = RUN_BITS'(1);
						dot_d  = 1'b0;
					end else begin
						vb    = 1'b1;
						tok_b = mk_tok(TK_ERROR, ERR_INVALID, off_q, 8'd1, line_out);
					end
				end
			end
			off_d = off_q + 1'b1;
		end
	end

	// pack the tokens of this byte into queue order and flag the final one
	always_comb begin
		push0  = va ? tok_a : tok_b;
		push1  = tok_b;
		n_push = {1'b0, va} + {1'b0, vb};
		if (n_push == 2'd2)
			push1.last = 1'b1;
		else
			push0.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pend_q   <= '0;
			dot_q    <= 1'b0;
			run_q    <= '0;
			kw_q     <= '0;
			tstart_q <= '0;
			off_q    <= '0;
			line_q   <= LINE_BITS'(1);
		end else if (src_acc) begin
			mode_q   <= mode_d;
			pend_q   <= pend_d;
			dot_q    <= dot_d;
			run_q    <= run_d;
			kw_q     <= kw_d;
			tstart_q <= tstart_d;
			off_q    <= off_d;
			line_q   <= line_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (src_acc)
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(n_push);
			if (tok_acc)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + QCNT_BITS'(src_acc ? n_push : 2'd0) - QCNT_BITS'(tok_acc);
		end
	end

	always_ff @(posedge clk) begin
		if (src_acc && n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= push0;
			if (n_push == 2'd2)
				fifo_q[wr_ptr_q + 1'b1] <= push1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= QCNT_BITS'(QDEPTH))
		else $error("result queue overfilled");

	assert property (@(posedge clk) disable iff (!arst_n)
		src_acc && src_item.at_end |=> mode_q == M_IDLE && off_q == '0 && line_q == LINE_BITS'(1))
		else $error("end mark did not restart the scanner");

	assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.token_kind == TK_END |-> tok_item.last)
		else $error("end token not flagged last");

	assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> ((tok_item.token_kind == TK_ERROR) == (tok_item.error_kind != ERR_NONE)))
		else $error("error kind disagrees with token kind");

endmodule

`default_nettype wire

// ===== verif/tb_source_tokenizer.sv =====
// Self-checking testbench for source_tokenizer: directed byte table, then random source text.
`default_nettype none

module tb_source_tokenizer;
	import stok_pkg::*;

	localparam int          LEXEME_MAX   = 255;
	localparam int          RUN_ITEMS    = 1500;
	localparam int          HOLD_AT      = 700;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 16;
	localparam int          CYCLE_LIMIT  = 2000000;
	localparam int          DIR_ROWS     = 25;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      src_valid;
	logic      src_stall;
	src_item_t src_item;
	logic      tok_valid;
	logic      tok_stall;
	tok_item_t tok_item;

	source_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item (src_item),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_item (tok_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// tokenizer state as the predictor sees it
	mode_t       lex_mode;
	logic [7:0]  lex_op_ch;
	logic        lex_dot;
	int unsigned lex_run;
	logic [31:0] lex_prefix;
	logic [23:0] lex_start;
	logic [23:0] lex_offset;
	logic [19:0] lex_line;
	tok_item_t   step_toks [2];
	int          step_n;

	tok_item_t   pending_tokens [$];
	tok_item_t   want_tok;
	int          mismatch_count = 0;
	int          tokens_checked = 0;
	int          items_sent = 0;
	int          cycle_count = 0;
	int          tx_calm = 0;
	int          rx_calm = 0;
	int          stall_len;
	bit          hold_rx = 1'b0;

	typedef struct {
		logic [7:0] ch;
		logic       at_end;
		bit         typed;
		tok_item_t  want;
	} dir_row_t;

	// typed rows carry the token read straight off the rules; the rest go to the predictor
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{"(",     1'b0, 1'b1, '{TK_LPAREN, ERR_NONE, 20'd1, 24'd0, 8'd1, 1'b1}},
		'{8'hFF,   1'b0, 1'b1, '{TK_ERROR, ERR_INVALID, 20'd1, 24'd1, 8'd1, 1'b1}},
		'{8'h00,   1'b0, 1'b1, '{TK_ERROR, ERR_INVALID, 20'd1, 24'd2, 8'd1, 1'b1}},
		'{"0",     1'b0, 1'b0, '0},
		'{"7",     1'b0, 1'b1, '{TK_ERROR, ERR_INVALID, 20'd1, 24'd3, 8'd1, 1'b1}},
		'{".",     1'b0, 1'b0, '0},
		'{"5",     1'b0, 1'b0, '0},
		'{".",     1'b0, 1'b0, '0},
		'{"a",     1'b0, 1'b0, '0},
		'{"Z",     1'b0, 1'b0, '0},
		'{CH_NL,   1'b0, 1'b0, '0},
		'{"/",     1'b0, 1'b0, '0},
		'{"/",     1'b0, 1'b0, '0},
		'{8'h80,   1'b0, 1'b0, '0},
		'{CH_NL,   1'b0, 1'b0, '0},
		'{"+",     1'b0, 1'b0, '0},
		'{"+",     1'b0, 1'b0, '0},
		'{"-",     1'b0, 1'b0, '0},
		'{"=",     1'b0, 1'b0, '0},
		'{"<",     1'b0, 1'b0, '0},
		'{8'hA5,   1'b1, 1'b0, '0},
		'{"9",     1'b0, 1'b0, '0},
		'{"q",     1'b0, 1'b1, '{TK_ERROR, ERR_LETTER, 20'd1, 24'd0, 8'd1, 1'b1}},
		'{"/",     1'b0, 1'b0, '0},
		'{8'h00,   1'b1, 1'b0, '0}
	};

	string      keywords [7] = '{"def", "let", "if", "then", "else", "and", "or"};
	string      op_chars = "()[]{}!:.,;+-*/%<>=";
	logic [7:0] ws_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [5:0] op_kind_base(input logic [7:0] c);
		case (c)
			CH_PLUS:    return TK_PLUS;
			CH_MINUS:   return TK_MINUS;
			CH_STAR:    return TK_STAR;
			CH_PERCENT: return TK_PERCENT;
			CH_LT:      return TK_LT;
			CH_GT:      return TK_GT;
			default:    return TK_ASSIGN;
		endcase
	endfunction

	function automatic void put_tok(input logic [5:0] kind, input logic [2:0] err,
			input logic [23:0] start, input int unsigned len);
		if (step_n < 2) begin
			step_toks[step_n] = '{token_kind: kind, error_kind: err, line: lex_line,
				start_offset: start, lexeme_length: (len > 255) ? LEN_OUT_MAX : 8'(len),
				last: 1'b0};
			step_n++;
		end
	endfunction

	function automatic void reset_lex();
		lex_mode   = M_IDLE;
		lex_op_ch  = 8'h00;
		lex_dot    = 1'b0;
		lex_run    = 0;
		lex_prefix = 32'h0;
		lex_start  = 24'h0;
		lex_offset = 24'h0;
		lex_line   = 20'd1;
	endfunction

	// byte seen between tokens: skip it, emit it, or open a new token
	function automatic void start_token(input logic [7:0] c);
		logic [5:0] pk;
		lex_mode = M_IDLE;
		if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
			if (c == CH_NL && lex_line != LINE_OUT_MAX)
				lex_line++;
			return;
		end
		case (c)
			"(":     pk = TK_LPAREN;
			")":     pk = TK_RPAREN;
			"[":     pk = TK_LBRACK;
			"]":     pk = TK_RBRACK;
			"{":     pk = TK_LBRACE;
			"}":     pk = TK_RBRACE;
			"!":     pk = TK_BANG;
			":":     pk = TK_COLON;
			".":     pk = TK_DOT;
			",":     pk = TK_COMMA;
			";":     pk = TK_SEMI;
			default: pk = TK_END;
		endcase
		if (pk != TK_END) begin
			put_tok(pk, ERR_NONE, lex_offset, 1);
			return;
		end
		lex_start = lex_offset;
		if (c == CH_SLASH) begin
			lex_mode = M_SLASH;
		end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_PERCENT ||
				c == CH_LT || c == CH_GT || c == CH_EQ) begin
			lex_mode  = M_OP;
			lex_op_ch = c;
		end else if (is_letter(c)) begin
			lex_mode   = M_IDENT;
			lex_run    = 1;
			lex_prefix = {24'h0, c};
		end else if (is_num(c)) begin
			lex_mode = (c == CH_ZERO) ? M_ZERO : M_NUMBER;
			lex_run  = 1;
			lex_dot  = 1'b0;
		end else begin
			put_tok(TK_ERROR, ERR_INVALID, lex_offset, 1);
		end
	endfunction

	function automatic void close_ident();
		logic [5:0] k;
		k = TK_IDENT;
		if (lex_run > LEXEME_MAX) begin
			put_tok(TK_ERROR, ERR_TOO_LONG, lex_start, lex_run);
			return;
		end
		case (lex_run)
			2: begin
				if (lex_prefix == KW_IF) k = TK_IF;
				else if (lex_prefix == KW_OR) k = TK_OR;
			end
			3: begin
				if (lex_prefix == KW_DEF) k = TK_DEF;
				else if (lex_prefix == KW_LET) k = TK_LET;
				else if (lex_prefix == KW_AND) k = TK_AND;
			end
			4: begin
				if (lex_prefix == KW_THEN) k = TK_THEN;
				else if (lex_prefix == KW_ELSE) k = TK_ELSE;
			end
			default: ;
		endcase
		put_tok(k, ERR_NONE, lex_start, lex_run);
	endfunction

	// has_term low: the number is closed by the end mark
	function automatic void close_number(input bit has_term, input logic [7:0] term);
		if (lex_run > LEXEME_MAX)
			put_tok(TK_ERROR, ERR_TOO_LONG, lex_start, lex_run);
		else if (has_term && term == CH_DOT && lex_dot)
			put_tok(TK_ERROR, ERR_DOT, lex_start, lex_run);
		else if (has_term && is_letter(term))
			put_tok(TK_ERROR, ERR_LETTER, lex_start, lex_run);
		else
			put_tok(TK_NUMBER, ERR_NONE, lex_start, lex_run);
	endfunction

	// tokens caused by one accepted byte or end mark, left in step_toks
	function automatic void scan_byte(input logic [7:0] c, input logic at_end);
		logic [5:0] base;
		step_n = 0;
		if (at_end) begin
			case (lex_mode)
				M_SLASH:          put_tok(TK_SLASH, ERR_NONE, lex_start, 1);
				M_OP:             put_tok(op_kind_base(lex_op_ch), ERR_NONE, lex_start, 1);
				M_IDENT:          close_ident();
				M_NUMBER, M_ZERO: close_number(1'b0, 8'h00);
				default: ;
			endcase
			put_tok(TK_END, ERR_NONE, lex_offset, 0);
			reset_lex();
		end else begin
			case (lex_mode)
				M_SLASH: begin
					if (c == CH_SLASH) begin
						lex_mode = M_COMMENT;
					end else if (c == CH_EQ) begin
						put_tok(TK_SLASH_EQ, ERR_NONE, lex_start, 2);
						lex_mode = M_IDLE;
					end else begin
						put_tok(TK_SLASH, ERR_NONE, lex_start, 1);
						start_token(c);
					end
				end
				M_COMMENT: begin
					if (c == CH_NL)
						start_token(c);
				end
				M_OP: begin
					base = op_kind_base(lex_op_ch);
					if (c == CH_EQ) begin
						put_tok(base + OP_EQ_STEP, ERR_NONE, lex_start, 2);
						lex_mode = M_IDLE;
					end else if (c == lex_op_ch && (c == CH_PLUS || c == CH_MINUS)) begin
						put_tok(base + OP_DBL_STEP, ERR_NONE, lex_start, 2);
						lex_mode = M_IDLE;
					end else begin
						put_tok(base, ERR_NONE, lex_start, 1);
						start_token(c);
					end
				end
				M_IDENT: begin
					if (is_letter(c) || is_num(c)) begin
						if (lex_run < 4)
							lex_prefix = {lex_prefix[23:0], c};
						if (lex_run <= LEXEME_MAX) lex_run++;
					end else begin
						close_ident();
						start_token(c);
					end
				end
				M_NUMBER, M_ZERO: begin
					if (lex_mode == M_ZERO && is_num(c)) begin
						// leading zero: the zero alone is bad, the digit opens a new number
						put_tok(TK_ERROR, ERR_INVALID, lex_start, 1);
						start_token(c);
					end else if (is_num(c) || (c == CH_DOT && !lex_dot)) begin
						if (c == CH_DOT) lex_dot = 1'b1;
						if (lex_run <= LEXEME_MAX) lex_run++;
						lex_mode = M_NUMBER;
					end else begin
						close_number(1'b1, c);
						start_token(c);
					end
				end
				default: start_token(c);
			endcase
			lex_offset++;
		end
		if (step_n > 0)
			step_toks[step_n - 1].last = 1'b1;
	endfunction

	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 99) == 0) begin
			calm = $urandom_range(20, 100);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 2);
		if (r < 97) return $urandom_range(3, 8);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [7:0] rand_letter();
		return 8'((($urandom_range(0, 1) != 0) ? "a" : "A") + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'(CH_ZERO + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_alnum();
		return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("token %0d: %s got %0d expected %0d", tokens_checked, field, got, want);
		mismatch_count++;
	endtask

	// offer one byte and wait for its transfer
	task automatic send_item(input logic [7:0] c, input logic at_end);
		int gap;
		gap = idle_len(tx_calm);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= '{ch: c, at_end: at_end};
		do @(posedge clk); while (src_stall);
		items_sent++;
		if (items_sent == HOLD_AT)
			hold_rx = 1'b1;
	endtask

	task automatic feed(input logic [7:0] c, input logic at_end);
		send_item(c, at_end);
		scan_byte(c, at_end);
		for (int k = 0; k < step_n; k++)
			pending_tokens.push_back(step_toks[k]);
	endtask

	task automatic feed_text(input string s);
		for (int i = 0; i < s.len(); i++)
			feed(s[i], 1'b0);
	endtask

	task automatic feed_long(input bit as_number, input int len);
		feed(as_number ? 8'(CH_ZERO + $urandom_range(1, 9)) : rand_letter(), 1'b0);
		repeat (len - 1)
			feed(as_number ? rand_digit() : rand_alnum(), 1'b0);
	endtask

	// one random lexeme, mostly well formed, sometimes broken or plain noise
	task automatic feed_chunk();
		int         pick;
		logic [7:0] c;
		pick = $urandom_range(0, 999);
		if (pick < 2) begin
			feed_long($urandom_range(0, 1), $urandom_range(250, 262));
		end else if (pick < 260) begin
			if ($urandom_range(0, 3) == 0) begin
				feed_text(keywords[$urandom_range(0, 6)]);
				if ($urandom_range(0, 4) == 0)
					feed(rand_alnum(), 1'b0);
			end else begin
				feed(rand_letter(), 1'b0);
				repeat ($urandom_range(0, 7))
					feed(rand_alnum(), 1'b0);
			end
		end else if (pick < 440) begin
			if ($urandom_range(0, 5) == 0)
				feed(CH_ZERO, 1'b0);
			repeat ($urandom_range(1, 5))
				feed(rand_digit(), 1'b0);
			case ($urandom_range(0, 5))
				0: begin
					feed(CH_DOT, 1'b0);
					repeat ($urandom_range(0, 3)) feed(rand_digit(), 1'b0);
				end
				1: begin
					feed(CH_DOT, 1'b0);
					repeat ($urandom_range(0, 2)) feed(rand_digit(), 1'b0);
					feed(CH_DOT, 1'b0);
				end
				2: feed(rand_letter(), 1'b0);
				default: ;
			endcase
		end else if (pick < 640) begin
			c = op_chars[$urandom_range(0, op_chars.len() - 1)];
			feed(c, 1'b0);
			case ($urandom_range(0, 3))
				0: feed(CH_EQ, 1'b0);
				1: feed(c, 1'b0);
				default: ;
			endcase
		end else if (pick < 800) begin
			repeat ($urandom_range(1, 3))
				feed(ws_chars[$urandom_range(0, 5)], 1'b0);
		end else if (pick < 850) begin
			feed(CH_SLASH, 1'b0);
			feed(CH_SLASH, 1'b0);
			repeat ($urandom_range(0, 10)) begin
				c = 8'($urandom_range(0, 255));
				feed((c == CH_NL) ? 8'h20 : c, 1'b0);
			end
			// now and then the end mark drops an open comment
			if ($urandom_range(0, 4) == 0)
				feed(8'($urandom_range(0, 255)), 1'b1);
			else
				feed(CH_NL, 1'b0);
		end else if (pick < 930) begin
			feed(8'($urandom_range(0, 255)), 1'b0);
		end else if (pick < 945) begin
			feed(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			feed(8'h20, 1'b0);
		end
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// output side: random stalls plus one long hold-off to back the block up
	initial begin
		tok_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				hold_rx = 1'b0;
				tok_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				tok_stall <= 1'b0;
			end else begin
				stall_len = idle_len(rx_calm);
				if (stall_len > 0) begin
					tok_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
				end
				tok_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && tok_valid && !tok_stall) begin
			if (pending_tokens.size() == 0) begin
				report_mismatch("token with nothing expected", tok_item.token_kind, 0);
			end else begin
				want_tok = pending_tokens.pop_front();
				if (tok_item.token_kind !== want_tok.token_kind)
					report_mismatch("token_kind", tok_item.token_kind, want_tok.token_kind);
				if (tok_item.error_kind !== want_tok.error_kind)
					report_mismatch("error_kind", tok_item.error_kind, want_tok.error_kind);
				if (tok_item.line !== want_tok.line)
					report_mismatch("line", tok_item.line, want_tok.line);
				if (tok_item.start_offset !== want_tok.start_offset)
					report_mismatch("start_offset", tok_item.start_offset, want_tok.start_offset);
				if (tok_item.lexeme_length !== want_tok.lexeme_length)
					report_mismatch("lexeme_length", tok_item.lexeme_length,
						want_tok.lexeme_length);
				if (tok_item.last !== want_tok.last)
					report_mismatch("last", tok_item.last, want_tok.last);
			end
			tokens_checked++;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		src_valid <= 1'b0;
		src_item  <= '0;
		reset_lex();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].ch, dir_rows[i].at_end);
			scan_byte(dir_rows[i].ch, dir_rows[i].at_end);
			if (dir_rows[i].typed) begin
				pending_tokens.push_back(dir_rows[i].want);
			end else begin
				for (int k = 0; k < step_n; k++)
					pending_tokens.push_back(step_toks[k]);
			end
		end

		// lexemes either side of the length limit
		feed_long(1'b0, LEXEME_MAX + 1);
		feed(8'h20, 1'b0);
		feed_long(1'b1, LEXEME_MAX);
		feed(8'h20, 1'b0);

		while (items_sent < RUN_ITEMS)
			feed_chunk();
		feed(8'($urandom_range(0, 255)), 1'b1);
		src_valid <= 1'b0;

		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
